// ----- rtl/core/assert_macros.svh -----
// Assertion helpers shared by the RTL. Each macro samples on clk and is
// disabled while rst_n is low, so the module using it must have both names.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define MHP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// The condition must never be true at a clock edge outside reset.
`define MHP_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ----- rtl/core/mhp_pkg.sv -----
package mhp_pkg;

    localparam int BYTE_W  = 8;
    localparam int ADDR_W  = 64;
    localparam int SHORT_W = 16;
    localparam int POS_W   = 5;
    localparam int CFG_IDX_W = 1;

    // Address mode codes from frame control.
    localparam logic [1:0] MODE_NONE  = 2'd0;
    localparam logic [1:0] MODE_RSVD  = 2'd1;
    localparam logic [1:0] MODE_SHORT = 2'd2;
    localparam logic [1:0] MODE_EXT   = 2'd3;

    // Address kind codes reported in the result word.
    localparam logic [1:0] KIND_NONE  = 2'd0;
    localparam logic [1:0] KIND_SHORT = 2'd1;
    localparam logic [1:0] KIND_EXT   = 2'd2;

    // Fixed header byte positions.
    localparam logic [POS_W-1:0] POS_FC_LO  = 5'd0;
    localparam logic [POS_W-1:0] POS_FC_HI  = 5'd1;
    localparam logic [POS_W-1:0] POS_SEQ    = 5'd2;
    localparam logic [POS_W-1:0] POS_PAN_LO = 5'd3;
    localparam logic [POS_W-1:0] POS_PAN_HI = 5'd4;
    localparam logic [POS_W-1:0] POS_ADDR   = 5'd5;
    localparam logic [POS_W-1:0] HDR_MAX_BYTES = 5'd21;

    localparam logic [3:0] LEN_NONE  = 4'd0;
    localparam logic [3:0] LEN_SHORT = 4'd2;
    localparam logic [3:0] LEN_EXT   = 4'd8;

    localparam logic [SHORT_W-1:0] SHORT_BROADCAST = 16'hFFFF;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_SHORT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_EXT   = 1'd1;

    typedef struct packed {
        logic               header_ok;
        logic [2:0]         frame_kind;
        logic [3:0]         control_flags;
        logic [BYTE_W-1:0]  seq_number;
        logic [SHORT_W-1:0] pan_ident;
        logic [1:0]         dest_kind;
        logic [ADDR_W-1:0]  dest_address;
        logic [1:0]         src_kind;
        logic [ADDR_W-1:0]  src_address;
        logic [POS_W-1:0]   header_bytes;
    } hdr_result_t;

endpackage

// ----- rtl/core/mhp_rx_if.sv -----
interface mhp_rx_if;
    import mhp_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;
    logic              frame_end;

    modport source (output valid, output rx_byte, output frame_end, input ready);
    modport sink (input valid, input rx_byte, input frame_end, output ready);
endinterface

// ----- rtl/core/mhp_hdr_if.sv -----
interface mhp_hdr_if;
    import mhp_pkg::*;

    logic               valid;
    logic               ready;
    logic               header_ok;
    logic [2:0]         frame_kind;
    logic [3:0]         control_flags;
    logic [BYTE_W-1:0]  seq_number;
    logic [SHORT_W-1:0] pan_ident;
    logic [1:0]         dest_kind;
    logic [ADDR_W-1:0]  dest_address;
    logic [1:0]         src_kind;
    logic [ADDR_W-1:0]  src_address;
    logic [POS_W-1:0]   header_bytes;

    modport source (
        output valid, output header_ok, output frame_kind, output control_flags,
        output seq_number, output pan_ident, output dest_kind, output dest_address,
        output src_kind, output src_address, output header_bytes, input ready
    );
    modport sink (
        input valid, input header_ok, input frame_kind, input control_flags,
        input seq_number, input pan_ident, input dest_kind, input dest_address,
        input src_kind, input src_address, input header_bytes, output ready
    );
endinterface

// ----- rtl/core/mhp_cfg_if.sv -----
interface mhp_cfg_if;
    import mhp_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [ADDR_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ----- rtl/core/mac_header_parser.sv -----
// Receive-side 802.15.4 MAC header decoder. Frame bytes enter on rx, one byte per
// cycle, and the decoded header leaves on hdr as a single word per frame, in the
// cycle after the byte that completes the header or the byte marked frame_end,
// whichever comes first. Every header byte updates the header registers in the
// cycle it is taken, so the parser sustains one byte per cycle; rx stalls only
// while the result register holds a word the sink has not taken. Short sources
// and destinations are widened to 64 bits, a short destination equal to
// own_short_address is replaced by own_extended_address, and the short broadcast
// address stays short. Bytes after a complete header are dropped until frame_end.
// The two address registers are written on cfg (index 0 short, index 1 extended),
// by the user only while the parser is idle; the block does not enforce this.
`include "assert_macros.svh"

module mac_header_parser (
    input  logic      clk,
    input  logic      rst_n,
    mhp_rx_if.sink    rx,
    mhp_hdr_if.source hdr,
    mhp_cfg_if.sink   cfg
);
    import mhp_pkg::*;

    function automatic logic [3:0] mode_len(input logic [1:0] mode);
        logic [3:0] len;
        case (mode)
            MODE_SHORT: len = LEN_SHORT;
            MODE_EXT:   len = LEN_EXT;
            default:    len = LEN_NONE;
        endcase
        return len;
    endfunction

    logic [POS_W-1:0]   pos_reg;
    logic               done_reg;
    logic [15:0]        fc_reg;
    logic [BYTE_W-1:0]  seq_reg;
    logic [SHORT_W-1:0] pan_reg;
    logic [ADDR_W-1:0]  dest_reg;
    logic [ADDR_W-1:0]  src_reg;
    logic [SHORT_W-1:0] own_short_reg;
    logic [ADDR_W-1:0]  own_ext_reg;
    hdr_result_t        res_reg;
    logic               res_valid_reg;

    logic [15:0]        fc_next;
    logic [BYTE_W-1:0]  seq_next;
    logic [SHORT_W-1:0] pan_next;
    logic [ADDR_W-1:0]  dest_next;
    logic [ADDR_W-1:0]  src_next;
    hdr_result_t        res_next;

    logic               rx_acc;
    logic [1:0]         dmode;
    logic [1:0]         smode;
    logic [POS_W-1:0]   dest_end;
    logic [POS_W-1:0]   src_end;
    logic [POS_W-1:0]   pos_inc;
    logic [2:0]         dest_lane;
    logic [2:0]         src_lane;
    logic [POS_W-1:0]   dest_off;
    logic [POS_W-1:0]   src_off;
    logic               complete;
    logic               emit;
    logic [SHORT_W-1:0] dest_short;

    assign rx.ready  = !res_valid_reg || hdr.ready;
    assign rx_acc    = rx.valid && rx.ready;
    assign cfg.ready = 1'b1;

    assign dmode    = fc_next[11:10];
    assign smode    = fc_next[15:14];
    assign dest_end = POS_ADDR + {1'b0, mode_len(dmode)};
    assign src_end  = dest_end + {1'b0, mode_len(smode)};
    assign pos_inc  = pos_reg + 5'd1;
    assign dest_off = pos_reg - POS_ADDR;
    assign src_off  = pos_reg - dest_end;
    assign dest_lane = dest_off[2:0];
    assign src_lane  = src_off[2:0];

    // Header field capture for the byte at the current position.
    always_comb
    begin
        fc_next   = fc_reg;
        seq_next  = seq_reg;
        pan_next  = pan_reg;
        dest_next = dest_reg;
        src_next  = src_reg;
        if (pos_reg == POS_FC_LO)
        begin
            fc_next[7:0] = rx.rx_byte;
        end
        else if (pos_reg == POS_FC_HI)
        begin
            fc_next[15:8] = rx.rx_byte;
        end
        else if (pos_reg == POS_SEQ)
        begin
            seq_next = rx.rx_byte;
        end
        else if (pos_reg == POS_PAN_LO)
        begin
            pan_next[7:0] = rx.rx_byte;
        end
        else if (pos_reg == POS_PAN_HI)
        begin
            pan_next[15:8] = rx.rx_byte;
        end
        else if (pos_reg < dest_end)
        begin
            dest_next[{dest_lane, 3'b000} +: BYTE_W] =
                dest_reg[{dest_lane, 3'b000} +: BYTE_W] | rx.rx_byte;
        end
        else if (pos_reg < src_end)
        begin
            src_next[{src_lane, 3'b000} +: BYTE_W] =
                src_reg[{src_lane, 3'b000} +: BYTE_W] | rx.rx_byte;
        end
    end

    assign complete   = (pos_inc >= POS_FC_HI + 5'd1) && (pos_inc >= src_end);
    assign emit       = rx_acc && !done_reg && (complete || rx.frame_end);
    assign dest_short = dest_next[SHORT_W-1:0];

    always_comb
    begin
        res_next.header_ok     = complete && (dmode != MODE_RSVD) && (smode != MODE_RSVD);
        res_next.frame_kind    = fc_next[2:0];
        res_next.control_flags = fc_next[6:3];
        res_next.seq_number    = seq_next;
        res_next.pan_ident     = pan_next;
        res_next.header_bytes  = pos_inc;

        res_next.dest_kind    = KIND_NONE;
        res_next.dest_address = '0;
        case (dmode)
            MODE_EXT:
            begin
                res_next.dest_kind    = KIND_EXT;
                res_next.dest_address = dest_next;
            end
            MODE_SHORT:
            begin
                // Substitution applies only once both address bytes are in.
                if (pos_inc >= dest_end && dest_short == own_short_reg)
                begin
                    res_next.dest_kind    = KIND_EXT;
                    res_next.dest_address = own_ext_reg;
                end
                else if (pos_inc >= dest_end && dest_short == SHORT_BROADCAST)
                begin
                    res_next.dest_kind    = KIND_SHORT;
                    res_next.dest_address = {{(ADDR_W-SHORT_W){1'b0}}, SHORT_BROADCAST};
                end
                else
                begin
                    res_next.dest_kind    = KIND_EXT;
                    res_next.dest_address = {{(ADDR_W-SHORT_W){1'b0}}, dest_short};
                end
            end
            default:
            begin
                res_next.dest_kind    = KIND_NONE;
                res_next.dest_address = '0;
            end
        endcase

        res_next.src_kind    = KIND_NONE;
        res_next.src_address = '0;
        case (smode)
            MODE_EXT:
            begin
                res_next.src_kind    = KIND_EXT;
                res_next.src_address = src_next;
            end
            MODE_SHORT:
            begin
                res_next.src_kind    = KIND_EXT;
                res_next.src_address = {{(ADDR_W-SHORT_W){1'b0}}, src_next[SHORT_W-1:0]};
            end
            default:
            begin
                res_next.src_kind    = KIND_NONE;
                res_next.src_address = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            done_reg <= 1'b0;
            fc_reg   <= '0;
            seq_reg  <= '0;
            pan_reg  <= '0;
            dest_reg <= '0;
            src_reg  <= '0;
        end
        else if (rx_acc)
        begin
            if (rx.frame_end)
            begin
                pos_reg  <= '0;
                done_reg <= 1'b0;
                fc_reg   <= '0;
                seq_reg  <= '0;
                pan_reg  <= '0;
                dest_reg <= '0;
                src_reg  <= '0;
            end
            else if (!done_reg)
            begin
                pos_reg  <= pos_inc;
                done_reg <= complete;
                fc_reg   <= fc_next;
                seq_reg  <= seq_next;
                pan_reg  <= pan_next;
                dest_reg <= dest_next;
                src_reg  <= src_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_short_reg <= '0;
            own_ext_reg   <= '0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_OWN_SHORT: own_short_reg <= cfg.data[SHORT_W-1:0];
                CFG_OWN_EXT:   own_ext_reg   <= cfg.data;
                default:       own_ext_reg   <= own_ext_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (hdr.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            res_reg <= res_next;
        end
    end

    assign hdr.valid         = res_valid_reg;
    assign hdr.header_ok     = res_reg.header_ok;
    assign hdr.frame_kind    = res_reg.frame_kind;
    assign hdr.control_flags = res_reg.control_flags;
    assign hdr.seq_number    = res_reg.seq_number;
    assign hdr.pan_ident     = res_reg.pan_ident;
    assign hdr.dest_kind     = res_reg.dest_kind;
    assign hdr.dest_address  = res_reg.dest_address;
    assign hdr.src_kind      = res_reg.src_kind;
    assign hdr.src_address   = res_reg.src_address;
    assign hdr.header_bytes  = res_reg.header_bytes;

    `MHP_ASSERT(a_pos_range, pos_reg <= HDR_MAX_BYTES, "byte position beyond longest header")
    `MHP_ASSERT(a_done_pos, done_reg |-> pos_reg >= POS_ADDR, "header done before fixed fields")
    `MHP_ASSERT(a_end_clears, (rx_acc && rx.frame_end) |=> (pos_reg == '0 && !done_reg), "frame end did not restart parser")
    `MHP_ASSERT_NEVER(a_ok_short, res_valid_reg && res_reg.header_ok && res_reg.header_bytes < POS_ADDR, "valid header shorter than fixed fields")

endmodule
